// ===== rtl/newton_fractal_cubic_pixel_assert.svh =====
`ifndef NEWTON_FRACTAL_CUBIC_PIXEL_ASSERT_SVH
`define NEWTON_FRACTAL_CUBIC_PIXEL_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define NFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nfc check failed");

// next-cycle implication, sampled on aclk, off during reset
`define NFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nfc check failed");

`endif

// ===== rtl/nfc_pkg.sv =====
package nfc_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int IMAGE_DIM    = 4096;

    localparam int COORD_W   = $clog2(IMAGE_DIM);
    localparam int PAL_IDX_W = 8;
    localparam int ITER_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC      = 28;
    localparam int ROOT_MUL  = 5;

    // Q4.28 constants, 34 bit signed to match the multiplier operands
    localparam logic signed [33:0] ONE_Q     = 34'sd268435456;
    localparam logic signed [33:0] HALF_Q    = 34'sd134217728;
    localparam logic signed [33:0] SQRT3_2_Q = 34'sd232471924;

    // Q8.56 bounds on squared magnitudes
    localparam logic signed [67:0] ESC_SQ = 68'sd288230376151711744;
    localparam logic signed [67:0] EPS_SQ = 68'sd720600336;

    // quotient magnitude cap, 16.0 in Q4.28
    localparam logic [32:0] QUOT_CAP = 33'h1_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_Y_ORIGIN = 3'd1,
        CFG_X_STEP   = 3'd2,
        CFG_Y_STEP   = 3'd3,
        CFG_MAX_ITER = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } pixel_in_t;

    typedef struct packed {
        logic                 converged;
        logic [1:0]           root_index;
        logic [ITER_W-1:0]    iterations;
        logic [PAL_IDX_W-1:0] palette_index;
    } pixel_out_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/newton_fractal_cubic_pixel.sv =====
// Newton fractal pixel engine for z^3 - 1 in signed Q4.28. A pixel (column,
// row) enters on the s_ channel, is mapped to z = (x_origin + column*x_step) +
// i*(y_origin - row*y_step), and Newton steps run until escape (|z| > 2),
// arrival within 1e-4 of a cube root of unity, a zero z^2, or max_iterations
// steps. One result transaction per pixel leaves on the m_ channel. All products
// go through one shared 34x34 multiplier, one per cycle, and both quotient
// components go through one shared radix-2 divider at up to 32 steps each. A
// Newton step is 18 multiplier slots, the first holding the limit check,
// followed by 2 divisions. The block takes one pixel at a time; s_ready is
// high only between pixels, while a finished result may still wait in the
// output register. Registers are written on the cfg_ channel (always ready)
// and should only change between pixels.
module newton_fractal_cubic_pixel (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  nfc_pkg::pixel_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output nfc_pkg::pixel_out_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [nfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);
    import nfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_LOOP,
        S_DIV_R,
        S_DIV_I,
        S_DONE
    } state_t;

    localparam logic [4:0] LAST_STEP = 5'd17;

    // configuration
    logic signed [31:0] x_origin_reg, y_origin_reg;
    logic [30:0]        x_step_reg, y_step_reg;
    logic [ITER_W-1:0]  max_iter_reg;

    // sequencer and working values
    state_t             state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    logic [COORD_W-1:0] col_reg, col_next, row_reg, row_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [1:0]         root_reg, root_next;
    logic               conv_reg, conv_next;
    logic signed [67:0] p_reg, p_next;
    logic signed [67:0] xsq_reg, xsq_next, ysq_reg, ysq_next;
    logic signed [67:0] t_reg, t_next, acc_reg, acc_next;
    logic signed [31:0] wr_reg, wr_next, wi_reg, wi_next;
    logic signed [33:0] nr_reg, nr_next, ni_reg, ni_next;
    logic [63:0]        den_reg, den_next;
    logic signed [63:0] numr_reg, numr_next, numi_reg, numi_next;
    logic signed [33:0] qr_reg, qr_next;
    logic               m_valid_reg, m_valid_next;
    pixel_out_t         m_data_reg, m_data_next;

    // shared multiplier operands
    logic signed [33:0] ma, mb;

    // divider hookup
    logic               div_start;
    logic signed [63:0] div_num;
    logic               div_done;
    logic signed [33:0] div_q;

    // combinational helpers
    logic signed [33:0] xs, ys, wrs, wis;
    logic signed [67:0] shr_tmp;
    logic signed [67:0] sum_tmp;
    logic signed [31:0] wi_calc;
    logic [10:0]        pal_sum;

    nfc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_q)
    );

    assign xs  = {{2{x_reg[31]}}, x_reg};
    assign ys  = {{2{y_reg[31]}}, y_reg};
    assign wrs = {{2{wr_reg[31]}}, wr_reg};
    assign wis = {{2{wi_reg[31]}}, wi_reg};

    assign p_next = ma * mb;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        iter_next    = iter_reg;
        root_next    = root_reg;
        conv_next    = conv_reg;
        xsq_next     = xsq_reg;
        ysq_next     = ysq_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        wr_next      = wr_reg;
        wi_next      = wi_reg;
        nr_next      = nr_reg;
        ni_next      = ni_reg;
        den_next     = den_reg;
        numr_next    = numr_reg;
        numi_next    = numi_reg;
        qr_next      = qr_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ma           = xs;
        mb           = xs;
        div_start    = 1'b0;
        div_num      = numr_reg;
        shr_tmp      = '0;
        sum_tmp      = '0;
        wi_calc      = p_reg[58:27];
        pal_sum      = 11'(root_reg) * 11'(ROOT_MUL) + 11'(iter_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    col_next   = s_data.column;
                    row_next   = s_data.row;
                    step_next  = '0;
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                // start point: column and row offsets through the multiplier
                ma = 34'(col_reg);
                mb = 34'(x_step_reg);
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd1) begin
                    ma     = 34'(row_reg);
                    mb     = 34'(y_step_reg);
                    x_next = sat32({{16{x_origin_reg[31]}}, x_origin_reg} + p_reg[47:0]);
                end else if (step_reg == 5'd2) begin
                    y_next     = sat32({{16{y_origin_reg[31]}}, y_origin_reg} - p_reg[47:0]);
                    iter_next  = '0;
                    root_next  = '0;
                    conv_next  = 1'b0;
                    step_next  = '0;
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0: begin
                        // iteration limit, checked before any test
                        ma = xs;
                        mb = xs;
                        if (iter_reg >= max_iter_reg) begin
                            state_next = S_DONE;
                        end
                    end
                    5'd1: begin
                        ma       = ys;
                        mb       = ys;
                        xsq_next = p_reg;
                    end
                    5'd2: begin
                        ma       = xs - ONE_Q;
                        mb       = xs - ONE_Q;
                        ysq_next = p_reg;
                    end
                    5'd3: begin
                        // escape test on |z|^2 > 4
                        ma     = xs + HALF_Q;
                        mb     = xs + HALF_Q;
                        t_next = p_reg;
                        if (xsq_reg + ysq_reg > ESC_SQ) begin
                            state_next = S_DONE;
                        end
                    end
                    5'd4: begin
                        // root 1 test
                        ma     = ys - SQRT3_2_Q;
                        mb     = ys - SQRT3_2_Q;
                        t_next = p_reg;
                        if (t_reg + ysq_reg < EPS_SQ) begin
                            root_next  = 2'd0;
                            conv_next  = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    5'd5: begin
                        // upper root test
                        ma = ys + SQRT3_2_Q;
                        mb = ys + SQRT3_2_Q;
                        if (t_reg + p_reg < EPS_SQ) begin
                            root_next  = 2'd1;
                            conv_next  = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    5'd6: begin
                        // lower root test, then re(z^2)
                        ma      = xs;
                        mb      = ys;
                        shr_tmp = (xsq_reg - ysq_reg) >>> FRAC;
                        wr_next = shr_tmp[31:0];
                        if (t_reg + p_reg < EPS_SQ) begin
                            root_next  = 2'd2;
                            conv_next  = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    5'd7: begin
                        // im(z^2) = floor(2xy), derivative zero check
                        ma      = xs;
                        mb      = wrs;
                        wi_next = wi_calc;
                        if (wr_reg == 32'sd0 && wi_calc == 32'sd0) begin
                            state_next = S_DONE;
                        end
                    end
                    5'd8: begin
                        ma       = ys;
                        mb       = wis;
                        acc_next = p_reg;
                    end
                    5'd9: begin
                        ma      = xs;
                        mb      = wis;
                        shr_tmp = (acc_reg - p_reg) >>> FRAC;
                        nr_next = shr_tmp[33:0] - ONE_Q;
                    end
                    5'd10: begin
                        ma       = ys;
                        mb       = wrs;
                        acc_next = p_reg;
                    end
                    5'd11: begin
                        ma      = wrs;
                        mb      = wrs;
                        shr_tmp = (acc_reg + p_reg) >>> FRAC;
                        ni_next = shr_tmp[33:0];
                    end
                    5'd12: begin
                        ma       = wis;
                        mb       = wis;
                        acc_next = p_reg;
                    end
                    5'd13: begin
                        // denominator 3|w|^2
                        ma       = nr_reg;
                        mb       = wrs;
                        sum_tmp  = acc_reg + p_reg;
                        den_next = sum_tmp[63:0] + {sum_tmp[62:0], 1'b0};
                    end
                    5'd14: begin
                        ma       = ni_reg;
                        mb       = wis;
                        acc_next = p_reg;
                    end
                    5'd15: begin
                        ma        = ni_reg;
                        mb        = wrs;
                        sum_tmp   = acc_reg + p_reg;
                        numr_next = sum_tmp[63:0];
                    end
                    5'd16: begin
                        ma       = nr_reg;
                        mb       = wis;
                        acc_next = p_reg;
                    end
                    LAST_STEP: begin
                        sum_tmp    = acc_reg - p_reg;
                        numi_next  = sum_tmp[63:0];
                        div_start  = 1'b1;
                        div_num    = numr_reg;
                        state_next = S_DIV_R;
                    end
                    default: begin
                        step_next = '0;
                    end
                endcase
            end
            S_DIV_R: begin
                if (div_done) begin
                    qr_next    = div_q;
                    div_start  = 1'b1;
                    div_num    = numi_reg;
                    state_next = S_DIV_I;
                end
            end
            S_DIV_I: begin
                if (div_done) begin
                    x_next     = sat32(48'(x_reg) - 48'(qr_reg));
                    y_next     = sat32(48'(y_reg) - 48'(div_q));
                    iter_next  = iter_reg + 1'b1;
                    step_next  = '0;
                    state_next = S_LOOP;
                end
            end
            S_DONE: begin
                // hand off once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.converged     = conv_reg;
                    m_data_next.root_index    = conv_reg ? root_reg : 2'd0;
                    m_data_next.iterations    = iter_reg;
                    m_data_next.palette_index = conv_reg
                        ? PAL_IDX_W'(pal_sum % PAL_ENTRIES) : '0;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            m_valid_reg  <= 1'b0;
            x_origin_reg <= -32'sd536870912;
            y_origin_reg <= 32'sd536870912;
            x_step_reg   <= 31'd262144;
            y_step_reg   <= 31'd262144;
            max_iter_reg <= 10'd50;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            // register writes; unknown indexes are dropped
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_X_ORIGIN: x_origin_reg <= cfg_data;
                    CFG_Y_ORIGIN: y_origin_reg <= cfg_data;
                    CFG_X_STEP:   x_step_reg   <= cfg_data[30:0];
                    CFG_Y_STEP:   y_step_reg   <= cfg_data[30:0];
                    CFG_MAX_ITER: max_iter_reg <= cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end
        end
        col_reg    <= col_next;
        row_reg    <= row_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        iter_reg   <= iter_next;
        root_reg   <= root_next;
        conv_reg   <= conv_next;
        p_reg      <= p_next;
        xsq_reg    <= xsq_next;
        ysq_reg    <= ysq_next;
        t_reg      <= t_next;
        acc_reg    <= acc_next;
        wr_reg     <= wr_next;
        wi_reg     <= wi_next;
        nr_reg     <= nr_next;
        ni_reg     <= ni_next;
        den_reg    <= den_next;
        numr_reg   <= numr_next;
        numi_reg   <= numi_next;
        qr_reg     <= qr_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== rtl/nfc_divider.sv =====
module nfc_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [63:0]  num,
    input  logic        [63:0]  den,
    output logic                done,
    output logic signed [33:0]  quo
);
    import nfc_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] sh_reg, sh_next;
    logic [32:0] q_reg, q_next;

    logic [63:0] mag;
    logic [63:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        mag       = num[63] ? 64'(-num) : 64'(num);
        trial     = {rem_reg[62:0], sh_reg[31]};
        if (start) begin
            neg_next = num[63];
            // integer part of 16 or more saturates at once
            if ({4'b0, mag} >= {den, 4'b0}) begin
                q_next    = QUOT_CAP;
                done_next = 1'b1;
            end else begin
                rem_next  = {4'b0, mag[63:4]};
                sh_next   = {mag[3:0], 28'b0};
                q_next    = '0;
                cnt_next  = 6'd32;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            // one restoring step per cycle
            if (trial >= den) begin
                rem_next = trial - den;
                q_next   = {q_reg[31:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[31:0], 1'b0};
            end
            sh_next  = {sh_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

// ===== rtl/nfc_checker.sv =====
`include "newton_fractal_cubic_pixel_assert.svh"

module nfc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input nfc_pkg::pixel_out_t m_data
);
    import nfc_pkg::*;

    // a waiting result holds until taken
    `NFC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // one pixel at a time: busy right after an accepted transaction
    `NFC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // unconverged pixels carry no root and no palette entry
    `NFC_ASSERT_SAME(a_unconv_zero, m_valid && !m_data.converged, m_data.root_index == 2'd0 && m_data.palette_index == 8'd0)
    // only three roots exist
    `NFC_ASSERT_SAME(a_root_range, m_valid, m_data.root_index != 2'd3)

endmodule

bind newton_fractal_cubic_pixel nfc_checker u_nfc_checker (.*);
